FILE: rtl/core/wsc_pkg.sv
`timescale 1ns / 1ps

package wsc_pkg;

	localparam logic [15:0] CTRL_LO = 16'hFF1A;
	localparam logic [15:0] CTRL_HI = 16'hFF1E;
	localparam logic [15:0] WAVE_LO = 16'hFF30;
	localparam logic [15:0] WAVE_HI = 16'hFF3F;

	localparam int CTRL_DEPTH = 5;
	localparam int WAVE_DEPTH = 16;

	localparam logic [2:0] REG_CTRL0   = 3'd0;
	localparam logic [2:0] REG_LENGTH  = 3'd1;
	localparam logic [2:0] REG_VOLUME  = 3'd2;
	localparam logic [2:0] REG_FREQ_LO = 3'd3;
	localparam logic [2:0] REG_FREQ_HI = 3'd4;

	localparam logic [11:0] PERIOD_BASE = 12'd2048;
	localparam logic [8:0]  LENGTH_BASE = 9'd256;

	typedef enum logic [1:0] {
		FUNC_READ   = 2'd0,
		FUNC_WRITE  = 2'd1,
		FUNC_PERIOD = 2'd2,
		FUNC_LENGTH = 2'd3
	} func_e;

	typedef struct packed {
		logic [7:0] wave_byte;
		logic       low_nibble;
		logic [1:0] volume;
		logic       channel_on;
	} voice_t;

	function automatic logic [12:0] reload_period(input logic [2:0] hi, input logic [7:0] lo);
		logic [11:0] span;
		span = PERIOD_BASE - {1'b0, hi, lo};
		return {span, 1'b0};
	endfunction

	function automatic logic [8:0] reload_length(input logic [7:0] value);
		return LENGTH_BASE - {1'b0, value};
	endfunction

endpackage

FILE: rtl/core/wavetable_sound_channel.sv
`timescale 1ns / 1ps
// An accepted item passes through the input register, then the result register.
// One item per cycle unless m_tready stalls; each item updates the channel state in a single pass.
// Back-pressure on m_tready stalls the result register and, while it holds an item, the input register.
// Reset (arst_n low, asynchronous): channel state registers and wave store clear to zero,
// channel marked running, both pipeline stages empty.

module wavetable_sound_channel (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [1:0]  s_tuser,   // func
	input  logic [23:0] s_tdata,   // address[15:0], write_data[23:16]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata    // read_data[7:0], level[12:8], channel_on[13], zero[15:14]
);
	import wsc_pkg::*;

	logic        valid_s1;
	func_e       func_s1;
	logic [15:0] addr_s1;
	logic [7:0]  data_s1;

	logic        out_valid_q;
	logic [7:0]  read_data_q;
	logic [4:0]  level_q;
	logic        on_q;

	logic        advance;
	logic        fire;
	logic [7:0]  read_data;
	voice_t      voice;
	logic signed [4:0] level;

	assign advance  = !out_valid_q || m_tready;
	assign fire     = valid_s1 && advance;
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			func_s1 <= func_e'(s_tuser);
			addr_s1 <= s_tdata[15:0];
			data_s1 <= s_tdata[23:16];
		end
	end

	wsc_state u_state (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (fire),
		.func       (func_s1),
		.address    (addr_s1),
		.write_data (data_s1),
		.read_data  (read_data),
		.voice      (voice)
	);

	wsc_level u_level (
		.voice (voice),
		.level (level)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			read_data_q <= read_data;
			level_q     <= unsigned'(level);
			on_q        <= voice.channel_on;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b00, on_q, level_q, read_data_q};

endmodule

FILE: rtl/core/wsc_state.sv
`timescale 1ns / 1ps

module wsc_state (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  wsc_pkg::func_e    func,
	input  logic [15:0]       address,
	input  logic [7:0]        write_data,
	output logic [7:0]        read_data,
	output wsc_pkg::voice_t   voice
);
	import wsc_pkg::*;

	logic [7:0]  ctrl_q [CTRL_DEPTH];
	logic [7:0]  wave_q [WAVE_DEPTH];
	logic [8:0]  length_q;
	logic [4:0]  pos_q;
	logic [1:0]  vol_q;
	logic [12:0] period_q;
	logic        run_q;

	logic [7:0]  ctrl_d [CTRL_DEPTH];
	logic [8:0]  length_d;
	logic [4:0]  pos_d;
	logic [1:0]  vol_d;
	logic [12:0] period_d;
	logic        run_d;
	logic        wave_we;

	logic        ctrl_hit;
	logic        wave_hit;
	logic [2:0]  reg_idx;
	logic [3:0]  wave_idx;

	assign ctrl_hit = (address >= CTRL_LO) && (address <= CTRL_HI);
	assign wave_hit = (address >= WAVE_LO) && (address <= WAVE_HI);
	assign reg_idx  = 3'(address[3:0] - CTRL_LO[3:0]);
	assign wave_idx = address[3:0];

	always_comb begin
		ctrl_d   = ctrl_q;
		length_d = length_q;
		pos_d    = pos_q;
		vol_d    = vol_q;
		period_d = period_q;
		run_d    = run_q;
		wave_we  = 1'b0;
		read_data = 8'h00;
		unique case (func)
			FUNC_READ: begin
				read_data = 8'hFF;
				if (ctrl_hit) begin
					unique case (reg_idx)
						REG_CTRL0:   read_data = ctrl_q[0];
						REG_LENGTH:  read_data = ctrl_q[1];
						REG_VOLUME:  read_data = ctrl_q[2];
						REG_FREQ_LO: read_data = ctrl_q[3];
						REG_FREQ_HI: read_data = ctrl_q[4];
						default:     read_data = 8'hFF;
					endcase
				end
			end
			FUNC_WRITE: begin
				if (wave_hit) begin
					wave_we = 1'b1;
				end else if (ctrl_hit) begin
					unique case (reg_idx)
						REG_CTRL0: begin
							ctrl_d[0] = write_data;
						end
						REG_LENGTH: begin
							ctrl_d[1] = write_data;
							length_d  = reload_length(write_data);
						end
						REG_VOLUME: begin
							ctrl_d[2] = write_data;
							vol_d     = write_data[6:5];
						end
						REG_FREQ_LO: begin
							ctrl_d[3] = write_data;
						end
						REG_FREQ_HI: begin
							ctrl_d[4] = write_data;
							if (write_data[7]) begin
								run_d = 1'b1;
								if (length_q == 9'd0) begin
									length_d = reload_length(ctrl_q[1]);
								end
								period_d = reload_period(write_data[2:0], ctrl_q[3]);
								vol_d    = ctrl_q[2][6:5];
								pos_d    = 5'd0;
							end
						end
						default: begin
						end
					endcase
				end
			end
			FUNC_PERIOD: begin
				if (period_q <= 13'd1) begin
					period_d = reload_period(ctrl_q[4][2:0], ctrl_q[3]);
					pos_d    = pos_q + 5'd1;
				end else begin
					period_d = period_q - 13'd1;
				end
			end
			FUNC_LENGTH: begin
				if (ctrl_q[4][6] && (length_q != 9'd0)) begin
					length_d = length_q - 9'd1;
					if (length_q == 9'd1) begin
						run_d = 1'b0;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		voice.wave_byte  = (wave_we && (wave_idx == pos_d[4:1])) ? write_data
		                                                         : wave_q[pos_d[4:1]];
		voice.low_nibble = pos_d[0];
		voice.volume     = vol_d;
		voice.channel_on = ctrl_d[0][7] && run_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CTRL_DEPTH; i++) begin
				ctrl_q[i] <= 8'h00;
			end
			for (int i = 0; i < WAVE_DEPTH; i++) begin
				wave_q[i] <= 8'h00;
			end
			length_q <= 9'd0;
			pos_q    <= 5'd0;
			vol_q    <= 2'd0;
			period_q <= 13'd0;
			run_q    <= 1'b1;
		end else if (fire) begin
			ctrl_q   <= ctrl_d;
			length_q <= length_d;
			pos_q    <= pos_d;
			vol_q    <= vol_d;
			period_q <= period_d;
			run_q    <= run_d;
			if (wave_we) begin
				wave_q[wave_idx] <= write_data;
			end
		end
	end

endmodule

FILE: rtl/core/wsc_level.sv
`timescale 1ns / 1ps

module wsc_level (
	input  wsc_pkg::voice_t   voice,
	output logic signed [4:0] level
);
	import wsc_pkg::*;

	logic [3:0] nibble;
	logic [3:0] sample;

	assign nibble = voice.low_nibble ? voice.wave_byte[3:0] : voice.wave_byte[7:4];

	always_comb begin
		case (voice.volume)
			2'd0:    sample = 4'd0;
			2'd1:    sample = nibble;
			2'd2:    sample = nibble >> 1;
			default: sample = nibble >> 2;
		endcase
	end

	assign level = signed'({sample, 1'b0} - 5'd15);

endmodule

FILE: rtl/core/wsc_checker.sv
`timescale 1ns / 1ps

module wsc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [1:0]  s_tuser,
	input logic [23:0] s_tdata,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata
);

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[15:14] == 2'b00))
		else $error("result padding not zero");

	a_level_odd: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[8] == 1'b1) && (m_tdata[12:8] != 5'b10000))
		else $error("level outside odd range -15..15");

	a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (m_tvalid && !m_tready))
		else $error("input stalled without output stall");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("stalled result changed");

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && !s_tready) |=> (s_tvalid && $stable(s_tdata) && $stable(s_tuser)))
		else $error("stalled input item changed");

endmodule

bind wavetable_sound_channel wsc_checker u_wsc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.s_tdata  (s_tdata),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

FILE: tb/channel_checker.sv
`timescale 1ns / 1ps

module channel_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [1:0]  s_tuser,   // func
	input  logic [23:0] s_tdata,   // address[15:0], write_data[23:16]
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [15:0] m_tdata,   // read_data[7:0], level[12:8], channel_on[13], zero[15:14]
	output int          mismatches,
	output int          outstanding,
	output int          compared
);
	import wsc_pkg::*;

	typedef struct packed {
		logic [7:0] read_data;
		logic [4:0] level;
		logic       channel_on;
	} chan_out_t;

	logic [7:0]  regs [CTRL_DEPTH];
	logic [7:0]  wave_mem [WAVE_DEPTH];
	logic [8:0]  len_left;
	logic [4:0]  position;
	logic [1:0]  vol;
	logic [12:0] divider;
	logic        running;

	chan_out_t due_outputs [$];

	function automatic logic [12:0] divider_reload();
		logic [12:0] freq;
		freq = {2'b00, regs[REG_FREQ_HI][2:0], regs[REG_FREQ_LO]};
		return 13'(2 * (13'd2048 - freq));
	endfunction

	task automatic advance_channel(input func_e fn, input logic [15:0] addr,
			input logic [7:0] wdata, output chan_out_t res);
		logic [2:0] idx;
		logic [7:0] rd;
		logic [7:0] wbyte;
		logic [3:0] nib;
		logic [3:0] s;
		logic       in_ctrl;
		logic       in_wave;
		idx = 3'(addr - CTRL_LO);
		in_ctrl = (addr >= CTRL_LO) && (addr <= CTRL_HI);
		in_wave = (addr >= WAVE_LO) && (addr <= WAVE_HI);
		rd = 8'h00;
		case (fn)
			FUNC_READ: begin
				rd = in_ctrl ? regs[idx] : 8'hFF;
			end
			FUNC_WRITE: begin
				if (in_wave) begin
					wave_mem[addr[3:0]] = wdata;
				end else if (in_ctrl) begin
					regs[idx] = wdata;
					if (idx == REG_LENGTH) begin
						len_left = 9'd256 - {1'b0, wdata};
					end else if (idx == REG_VOLUME) begin
						vol = wdata[6:5];
					end else if (idx == REG_FREQ_HI && wdata[7]) begin
						running = 1'b1;
						if (len_left == 9'd0)
							len_left = 9'd256 - {1'b0, regs[REG_LENGTH]};
						divider = divider_reload();
						vol = regs[REG_VOLUME][6:5];
						position = 5'd0;
					end
				end
			end
			FUNC_PERIOD: begin
				if (divider <= 13'd1) begin
					divider = divider_reload();
					position = position + 5'd1;
				end else begin
					divider = divider - 13'd1;
				end
			end
			default: begin
				if (regs[REG_FREQ_HI][6] && len_left != 9'd0) begin
					len_left = len_left - 9'd1;
					if (len_left == 9'd0)
						running = 1'b0;
				end
			end
		endcase
		wbyte = wave_mem[position[4:1]];
		nib = position[0] ? wbyte[3:0] : wbyte[7:4];
		case (vol)
			2'd0: s = 4'd0;
			2'd1: s = nib;
			2'd2: s = nib >> 1;
			default: s = nib >> 2;
		endcase
		res.read_data = rd;
		res.level = {s, 1'b0} - 5'd15;
		res.channel_on = regs[REG_CTRL0][7] & running;
	endtask

	always @(posedge clk or negedge arst_n) begin
		chan_out_t got;
		chan_out_t want;
		chan_out_t produced;
		int        errs;
		if (!arst_n) begin
			for (int i = 0; i < CTRL_DEPTH; i++)
				regs[i] = 8'h00;
			for (int i = 0; i < WAVE_DEPTH; i++)
				wave_mem[i] = 8'h00;
			len_left = 9'd0;
			position = 5'd0;
			vol = 2'd0;
			divider = 13'd0;
			running = 1'b1;
			due_outputs.delete();
			mismatches <= 0;
			outstanding <= 0;
			compared <= 0;
		end else begin
			errs = 0;
			if (m_tvalid && m_tready) begin
				got.read_data = m_tdata[7:0];
				got.level = m_tdata[12:8];
				got.channel_on = m_tdata[13];
				if (due_outputs.size() == 0) begin
					$error("result %h arrived with nothing expected", m_tdata);
					errs++;
				end else begin
					want = due_outputs.pop_front();
					compared <= compared + 1;
					if (got.read_data !== want.read_data) begin
						$error("read_data: expected %0h, got %0h", want.read_data,
							got.read_data);
						errs++;
					end
					if (got.level !== want.level) begin
						$error("level: expected %0d, got %0d", $signed(want.level),
							$signed(got.level));
						errs++;
					end
					if (got.channel_on !== want.channel_on) begin
						$error("channel_on: expected %0b, got %0b", want.channel_on,
							got.channel_on);
						errs++;
					end
				end
			end
			if (errs != 0)
				mismatches <= mismatches + errs;
			if (s_tvalid && s_tready) begin
				advance_channel(func_e'(s_tuser), s_tdata[15:0], s_tdata[23:16], produced);
				due_outputs.push_back(produced);
			end
			outstanding <= due_outputs.size();
		end
	end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps

module tb;
	import wsc_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int RANDOM_PER_PHASE = 300;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [1:0]  s_tuser = 2'd0;   // func
	logic [23:0] s_tdata = 24'd0;  // address[15:0], write_data[23:16]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;          // read_data[7:0], level[12:8], channel_on[13], zero[15:14]

	int mismatches;
	int outstanding;
	int compared;
	int cycle_count = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int func_count [4];

	always #4 clk = ~clk;

	wavetable_sound_channel DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	channel_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tuser     (s_tuser),
		.s_tdata     (s_tdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.mismatches  (mismatches),
		.outstanding (outstanding),
		.compared    (compared)
	);

	always @(posedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	function automatic logic [15:0] reg_addr(input logic [2:0] idx);
		return CTRL_LO + {13'd0, idx};
	endfunction

	task automatic send_item(input func_e fn, input logic [15:0] addr, input logic [7:0] data);
		logic rdy;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= fn;
		s_tdata <= {data, addr};
		do begin
			@(negedge clk);
			rdy = s_tready;
			@(posedge clk);
		end while (!rdy);
		func_count[fn]++;
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		do
			@(negedge clk);
		while (outstanding != 0);
		@(posedge clk);
	endtask

	task automatic send_random();
		int pick;
		int r;
		logic [2:0] idx;
		logic [7:0] data;
		pick = $urandom_range(0, 99);
		if (pick < 30) begin
			send_item(FUNC_PERIOD, 16'($urandom), 8'($urandom));
		end else if (pick < 42) begin
			send_item(FUNC_LENGTH, 16'($urandom), 8'($urandom));
		end else if (pick < 57) begin
			r = $urandom_range(0, 99);
			if (r < 70)
				send_item(FUNC_READ, reg_addr(3'($urandom_range(0, 4))), 8'($urandom));
			else if (r < 85)
				send_item(FUNC_READ, WAVE_LO + 16'($urandom_range(0, 15)), 8'($urandom));
			else
				send_item(FUNC_READ, 16'($urandom), 8'($urandom));
		end else begin
			r = $urandom_range(0, 99);
			if (r < 30) begin
				send_item(FUNC_WRITE, WAVE_LO + 16'($urandom_range(0, 15)), 8'($urandom));
			end else if (r < 85) begin
				idx = 3'($urandom_range(0, 4));
				data = 8'($urandom);
				case (idx)
					REG_CTRL0: data[7] = ($urandom_range(0, 3) != 0);
					REG_LENGTH: if ($urandom_range(0, 9) < 7) data = 8'($urandom_range(240, 255));
					REG_FREQ_LO: if ($urandom_range(0, 3) != 0) data = 8'($urandom_range(240, 255));
					REG_FREQ_HI: if ($urandom_range(0, 3) != 0) data[2:0] = 3'd7;
					default: ;
				endcase
				send_item(FUNC_WRITE, reg_addr(idx), data);
			end else begin
				send_item(FUNC_WRITE, 16'($urandom), 8'($urandom));
			end
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 11;
		recv_stall_pct = 59;

		send_item(FUNC_READ, reg_addr(REG_CTRL0), 8'h00);
		send_item(FUNC_READ, reg_addr(REG_FREQ_HI), 8'hFF);
		send_item(FUNC_READ, 16'h0000, 8'h00);
		send_item(FUNC_READ, 16'hFFFF, 8'hFF);
		send_item(FUNC_READ, WAVE_LO, 8'h00);
		send_item(FUNC_WRITE, CTRL_LO - 16'd1, 8'hFF);
		send_item(FUNC_WRITE, CTRL_HI + 16'd1, 8'hFF);
		send_item(FUNC_WRITE, WAVE_LO, 8'h0F);
		send_item(FUNC_WRITE, WAVE_HI, 8'hF0);
		send_item(FUNC_WRITE, WAVE_LO + 16'd1, 8'hA5);
		send_item(FUNC_READ, WAVE_HI, 8'h00);
		send_item(FUNC_WRITE, reg_addr(REG_CTRL0), 8'h80);
		send_item(FUNC_WRITE, reg_addr(REG_VOLUME), 8'h20);
		send_item(FUNC_WRITE, reg_addr(REG_FREQ_LO), 8'hFF);
		send_item(FUNC_WRITE, reg_addr(REG_FREQ_HI), 8'h07);
		repeat (4) send_item(FUNC_PERIOD, 16'h0000, 8'h00);
		send_item(FUNC_WRITE, reg_addr(REG_LENGTH), 8'hFF);
		send_item(FUNC_LENGTH, 16'hFFFF, 8'hFF);
		send_item(FUNC_WRITE, reg_addr(REG_FREQ_HI), 8'hC7);
		repeat (2) send_item(FUNC_LENGTH, 16'h0000, 8'h00);
		send_item(FUNC_WRITE, reg_addr(REG_FREQ_HI), 8'h87);
		send_item(FUNC_WRITE, reg_addr(REG_VOLUME), 8'h60);
		send_item(FUNC_PERIOD, 16'h0000, 8'h00);
		send_item(FUNC_WRITE, reg_addr(REG_VOLUME), 8'h40);
		send_item(FUNC_WRITE, reg_addr(REG_VOLUME), 8'h00);
		send_item(FUNC_READ, reg_addr(REG_LENGTH), 8'h00);
		send_item(FUNC_READ, reg_addr(REG_VOLUME), 8'h00);
		send_item(FUNC_READ, reg_addr(REG_FREQ_LO), 8'h00);
		send_item(FUNC_WRITE, reg_addr(REG_LENGTH), 8'h00);
		send_item(FUNC_WRITE, reg_addr(REG_FREQ_LO), 8'h00);
		send_item(FUNC_WRITE, reg_addr(REG_FREQ_HI), 8'h80);
		send_item(FUNC_PERIOD, 16'h0000, 8'h00);
		drain_results();

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin send_idle_pct = 11; recv_stall_pct = 59; end
				1: begin send_idle_pct = 59; recv_stall_pct = 11; end
				default: begin send_idle_pct = 0; recv_stall_pct = 0; end
			endcase
			repeat (RANDOM_PER_PHASE) send_random();
			drain_results();
		end

		repeat (8) @(posedge clk);
		$display("Items sent: %0d reads, %0d writes, %0d period ticks, %0d length ticks",
			func_count[FUNC_READ], func_count[FUNC_WRITE], func_count[FUNC_PERIOD],
			func_count[FUNC_LENGTH]);
		$display("Results compared: %0d, mismatches: %0d", compared, mismatches);
		if (mismatches == 0 && outstanding == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

FILE: wavetable_sound_channel.f
rtl/core/wsc_pkg.sv
rtl/core/wsc_state.sv
rtl/core/wsc_level.sv
rtl/core/wavetable_sound_channel.sv
rtl/core/wsc_checker.sv
tb/channel_checker.sv
tb/tb.sv
